/* rtl/sqt_pkg.sv */
// ----------------------------------------------------------------------------
// sqt_pkg
// Shared widths, constants and helpers for the sprite quad transform:
// coordinate formats, saturation, min/max and the quarter-wave sine entries.
// ----------------------------------------------------------------------------
package sqt_pkg;

    // Field widths
    localparam int COORD_W   = 24;  // signed Q15.8 coordinate
    localparam int SIZE_W    = 23;  // unsigned Q15.8 size
    localparam int SCALE_W   = 16;  // signed Q8.8 scale
    localparam int ANGLE_W   = 16;  // full turn = 2^16
    localparam int PHASE_W   = 14;  // angle bits below the quadrant

    // Internal widths
    localparam int LOCAL_W   = 25;  // local corner, size - pivot
    localparam int SINE_W    = 15;  // unsigned Q1.14 table entry
    localparam int TRIG_W    = 16;  // signed Q1.14 sine or cosine
    localparam int COEF_W    = 31;  // matrix coefficient, Q.22
    localparam int PROD_W    = 56;  // local * coefficient
    localparam int SUM_W     = 57;  // two products plus rounding constant
    localparam int FRAC_SHIFT = 22;
    localparam int SHIFTED_W = SUM_W - FRAC_SHIFT;  // 35
    localparam int EXT_W     = SHIFTED_W + 1;       // after adding the destination

    localparam int SINE_TABLE_BITS_DEF = 10;

    localparam logic signed [SUM_W-1:0]   ROUND_HALF = SUM_W'(64'd1 << (FRAC_SHIFT - 1));
    localparam logic signed [COORD_W-1:0] COORD_MAX  = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN  = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic [SINE_W-1:0]         SINE_ONE   = SINE_W'(16384);
    localparam logic [63:0]               PI_HALF_Q30 = 64'd1686629713;

    // Enables of the three stages inside an axis unit
    typedef struct packed {
        logic mul;
        logic sum;
        logic sat;
    } t_axis_en;

    // Clamp a widened coordinate to the Q15.8 range
    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [EXT_W-1:0] v);
        logic signed [EXT_W-1:0] hi;
        logic signed [EXT_W-1:0] lo;
        hi = EXT_W'(COORD_MAX);
        lo = EXT_W'(COORD_MIN);
        if (v > hi) begin
            return COORD_MAX;
        end else if (v < lo) begin
            return COORD_MIN;
        end
        return v[COORD_W-1:0];
    endfunction

    function automatic logic signed [COORD_W-1:0] min2(input logic signed [COORD_W-1:0] a,
                                                       input logic signed [COORD_W-1:0] b);
        return (b < a) ? b : a;
    endfunction

    function automatic logic signed [COORD_W-1:0] max2(input logic signed [COORD_W-1:0] a,
                                                       input logic signed [COORD_W-1:0] b);
        return (b > a) ? b : a;
    endfunction

    // Unsigned restoring division, one quotient bit per step; elaboration only.
    function automatic logic [63:0] udiv64(input logic [63:0] num,
                                           input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Quarter-wave sine entry i of a table with 2^bits + 1 entries, Q1.14.
    // Q2.30 Taylor series up to x^17 with truncating shifts, rounded half up.
    // Evaluated at elaboration only.
    function automatic logic [SINE_W-1:0] sine_entry(input int unsigned idx,
                                                     input int unsigned bits);
        logic [63:0]        x;
        logic [63:0]        term;
        logic [63:0]        div;
        logic signed [63:0] sum;
        logic [63:0]        r;
        x    = (64'(idx) * PI_HALF_Q30) >> bits;
        term = x;
        sum  = $signed(x);
        for (int n = 1; n <= 8; n++) begin
            div  = 64'((2 * n) * (2 * n + 1));
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = udiv64(term, div);
            if (n[0] == 1'b1) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            sum = '0;
        end
        r = (64'(sum) + 64'd32768) >> 16;
        if (r > 64'(SINE_ONE)) begin
            r = 64'(SINE_ONE);
        end
        return r[SINE_W-1:0];
    endfunction

endpackage

/* rtl/sqt_sine_rom.sv */
// ----------------------------------------------------------------------------
// sqt_sine_rom
// Quarter-wave sine ROM, 2^TABLE_BITS + 1 entries, two registered read ports.
// ----------------------------------------------------------------------------
module sqt_sine_rom #(
    parameter int TABLE_BITS = sqt_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [TABLE_BITS:0]         i_addr_a,
    input  logic [TABLE_BITS:0]         i_addr_b,
    output logic [sqt_pkg::SINE_W-1:0]  o_data_a,
    output logic [sqt_pkg::SINE_W-1:0]  o_data_b
);

    localparam int ENTRIES = (2 ** TABLE_BITS) + 1;

    logic [sqt_pkg::SINE_W-1:0] rom [ENTRIES];
    logic [sqt_pkg::SINE_W-1:0] r_data_a;
    logic [sqt_pkg::SINE_W-1:0] r_data_b;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_entry
        localparam logic [sqt_pkg::SINE_W-1:0] VALUE = sqt_pkg::sine_entry(g, TABLE_BITS);
        assign rom[g] = VALUE;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data_a <= rom[i_addr_a];
            r_data_b <= rom[i_addr_b];
        end
    end

    assign o_data_a = r_data_a;
    assign o_data_b = r_data_b;

endmodule

/* rtl/sqt_axis.sv */
// ----------------------------------------------------------------------------
// sqt_axis
// One output axis of all four corners: multiply, round, translate, saturate.
// Corners pair (u0,v0), (u1,v0), (u1,v1), (u0,v1), clockwise from top left.
// ----------------------------------------------------------------------------
module sqt_axis (
    input  logic                                i_clk,
    input  sqt_pkg::t_axis_en                   i_en,
    input  logic signed [sqt_pkg::LOCAL_W-1:0]  i_u0,
    input  logic signed [sqt_pkg::LOCAL_W-1:0]  i_u1,
    input  logic signed [sqt_pkg::LOCAL_W-1:0]  i_v0,
    input  logic signed [sqt_pkg::LOCAL_W-1:0]  i_v1,
    input  logic signed [sqt_pkg::COEF_W-1:0]   i_ma,
    input  logic signed [sqt_pkg::COEF_W-1:0]   i_mb,
    input  logic signed [sqt_pkg::COORD_W-1:0]  i_dest,
    output logic signed [sqt_pkg::COORD_W-1:0]  o_c0,
    output logic signed [sqt_pkg::COORD_W-1:0]  o_c1,
    output logic signed [sqt_pkg::COORD_W-1:0]  o_c2,
    output logic signed [sqt_pkg::COORD_W-1:0]  o_c3
);

    logic signed [sqt_pkg::PROD_W-1:0]    n_pu0, n_pu1, n_pv0, n_pv1;
    logic signed [sqt_pkg::PROD_W-1:0]    r_pu0, r_pu1, r_pv0, r_pv1;
    logic signed [sqt_pkg::COORD_W-1:0]   r_dest_m, r_dest_s;
    logic signed [sqt_pkg::SUM_W-1:0]     n_sum [4];
    logic signed [sqt_pkg::SHIFTED_W-1:0] r_rnd [4];
    logic signed [sqt_pkg::COORD_W-1:0]   r_c [4];

    // Four products per axis
    assign n_pu0 = i_u0 * i_ma;
    assign n_pu1 = i_u1 * i_ma;
    assign n_pv0 = i_v0 * i_mb;
    assign n_pv1 = i_v1 * i_mb;

    always_ff @(posedge i_clk) begin
        if (i_en.mul) begin
            r_pu0    <= n_pu0;
            r_pu1    <= n_pu1;
            r_pv0    <= n_pv0;
            r_pv1    <= n_pv1;
            r_dest_m <= i_dest;
        end
    end

    // Exact sum, then a single round half up (floor after adding one half)
    assign n_sum[0] = sqt_pkg::SUM_W'(r_pu0) + sqt_pkg::SUM_W'(r_pv0) + sqt_pkg::ROUND_HALF;
    assign n_sum[1] = sqt_pkg::SUM_W'(r_pu1) + sqt_pkg::SUM_W'(r_pv0) + sqt_pkg::ROUND_HALF;
    assign n_sum[2] = sqt_pkg::SUM_W'(r_pu1) + sqt_pkg::SUM_W'(r_pv1) + sqt_pkg::ROUND_HALF;
    assign n_sum[3] = sqt_pkg::SUM_W'(r_pu0) + sqt_pkg::SUM_W'(r_pv1) + sqt_pkg::ROUND_HALF;

    always_ff @(posedge i_clk) begin
        if (i_en.sum) begin
            for (int k = 0; k < 4; k++) begin
                r_rnd[k] <= n_sum[k][sqt_pkg::SUM_W-1:sqt_pkg::FRAC_SHIFT];
            end
            r_dest_s <= r_dest_m;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.sat) begin
            for (int k = 0; k < 4; k++) begin
                r_c[k] <= sqt_pkg::sat_coord(sqt_pkg::EXT_W'(r_rnd[k])
                                             + sqt_pkg::EXT_W'(r_dest_s));
            end
        end
    end

    assign o_c0 = r_c[0];
    assign o_c1 = r_c[1];
    assign o_c2 = r_c[2];
    assign o_c3 = r_c[3];

endmodule

/* rtl/sqt_bbox.sv */
// ----------------------------------------------------------------------------
// sqt_bbox
// Output stage: hold the four corners and their axis-aligned bounding box.
// ----------------------------------------------------------------------------
module sqt_bbox (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [sqt_pkg::COORD_W-1:0]  i_x [4],
    input  logic signed [sqt_pkg::COORD_W-1:0]  i_y [4],
    output logic signed [sqt_pkg::COORD_W-1:0]  o_x [4],
    output logic signed [sqt_pkg::COORD_W-1:0]  o_y [4],
    output logic signed [sqt_pkg::COORD_W-1:0]  o_min_x,
    output logic signed [sqt_pkg::COORD_W-1:0]  o_min_y,
    output logic signed [sqt_pkg::COORD_W-1:0]  o_max_x,
    output logic signed [sqt_pkg::COORD_W-1:0]  o_max_y
);

    logic signed [sqt_pkg::COORD_W-1:0] n_min_x, n_min_y, n_max_x, n_max_y;
    logic signed [sqt_pkg::COORD_W-1:0] r_x [4];
    logic signed [sqt_pkg::COORD_W-1:0] r_y [4];
    logic signed [sqt_pkg::COORD_W-1:0] r_min_x, r_min_y, r_max_x, r_max_y;

    // Two-level compare trees
    assign n_min_x = sqt_pkg::min2(sqt_pkg::min2(i_x[0], i_x[1]), sqt_pkg::min2(i_x[2], i_x[3]));
    assign n_min_y = sqt_pkg::min2(sqt_pkg::min2(i_y[0], i_y[1]), sqt_pkg::min2(i_y[2], i_y[3]));
    assign n_max_x = sqt_pkg::max2(sqt_pkg::max2(i_x[0], i_x[1]), sqt_pkg::max2(i_x[2], i_x[3]));
    assign n_max_y = sqt_pkg::max2(sqt_pkg::max2(i_y[0], i_y[1]), sqt_pkg::max2(i_y[2], i_y[3]));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x     <= i_x;
            r_y     <= i_y;
            r_min_x <= n_min_x;
            r_min_y <= n_min_y;
            r_max_x <= n_max_x;
            r_max_y <= n_max_y;
        end
    end

    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_min_x = r_min_x;
    assign o_min_y = r_min_y;
    assign o_max_x = r_max_x;
    assign o_max_y = r_max_y;

endmodule

/* rtl/sprite_quad_transform.sv */
// ----------------------------------------------------------------------------
// sprite_quad_transform
// Throughput: one item per cycle while the output is not stalled; six register
// stages, each with its own valid.
// A stage advances when it is empty or the stage after it advances, so bubbles
// are squeezed out while the output is stalled.
// Reset (synchronous, active low) empties every stage; payload is not reset.
// ----------------------------------------------------------------------------
module sprite_quad_transform #(
    parameter int SINE_TABLE_BITS = sqt_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Sprite item
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [sqt_pkg::COORD_W-1:0]    i_dest_x,
    input  logic signed [sqt_pkg::COORD_W-1:0]    i_dest_y,
    input  logic        [sqt_pkg::SIZE_W-1:0]     i_size_w,
    input  logic        [sqt_pkg::SIZE_W-1:0]     i_size_h,
    input  logic signed [sqt_pkg::COORD_W-1:0]    i_pivot_x,
    input  logic signed [sqt_pkg::COORD_W-1:0]    i_pivot_y,
    input  logic signed [sqt_pkg::SCALE_W-1:0]    i_scale_x,
    input  logic signed [sqt_pkg::SCALE_W-1:0]    i_scale_y,
    input  logic        [sqt_pkg::ANGLE_W-1:0]    i_angle,
    // Quad item
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [sqt_pkg::COORD_W-1:0]    o_tl_x,
    output logic signed [sqt_pkg::COORD_W-1:0]    o_tl_y,
    output logic signed [sqt_pkg::COORD_W-1:0]    o_tr_x,
    output logic signed [sqt_pkg::COORD_W-1:0]    o_tr_y,
    output logic signed [sqt_pkg::COORD_W-1:0]    o_br_x,
    output logic signed [sqt_pkg::COORD_W-1:0]    o_br_y,
    output logic signed [sqt_pkg::COORD_W-1:0]    o_bl_x,
    output logic signed [sqt_pkg::COORD_W-1:0]    o_bl_y,
    output logic signed [sqt_pkg::COORD_W-1:0]    o_box_min_x,
    output logic signed [sqt_pkg::COORD_W-1:0]    o_box_min_y,
    output logic signed [sqt_pkg::COORD_W-1:0]    o_box_max_x,
    output logic signed [sqt_pkg::COORD_W-1:0]    o_box_max_y
);

    localparam int NUM_STAGES = 6;
    localparam int STG_ROM  = 0;  // table read, local corners
    localparam int STG_COEF = 1;  // rotation-scale matrix
    localparam int STG_MUL  = 2;  // corner products
    localparam int STG_SUM  = 3;  // sum and round
    localparam int STG_SAT  = 4;  // translate and saturate
    localparam int STG_OUT  = 5;  // bounding box, output register

    localparam int LW = sqt_pkg::LOCAL_W;
    localparam int CW = sqt_pkg::COORD_W;
    localparam logic [SINE_TABLE_BITS:0] QUARTER = {1'b1, {SINE_TABLE_BITS{1'b0}}};

    // ------------------------------------------------------------------
    // Flow control: one valid per stage, enables ripple back from the output
    // ------------------------------------------------------------------
    logic [NUM_STAGES-1:0] r_valid;
    logic [NUM_STAGES-1:0] stage_en;
    logic [NUM_STAGES-1:0] n_valid;

    always_comb begin
        stage_en[STG_OUT] = !r_valid[STG_OUT] || !i_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !r_valid[k] || stage_en[k+1];
        end
        n_valid[0] = i_valid;
        for (int k = 1; k < NUM_STAGES; k++) begin
            n_valid[k] = r_valid[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            for (int k = 0; k < NUM_STAGES; k++) begin
                if (stage_en[k]) begin
                    r_valid[k] <= n_valid[k];
                end
            end
        end
    end

    assign o_stall = !stage_en[STG_ROM];
    assign o_valid = r_valid[STG_OUT];

    // ------------------------------------------------------------------
    // Stage 0: sine and cosine addresses, local corners
    // The phase keeps its top table bits (truncation); odd quadrants mirror
    // the address. Cosine is the sine a quarter turn on, so its quadrant is
    // one higher: it mirrors on even sine quadrants and negates in quadrants
    // one and two.
    // ------------------------------------------------------------------
    logic [SINE_TABLE_BITS-1:0] phase_idx;
    logic [SINE_TABLE_BITS:0]   sin_addr;
    logic [SINE_TABLE_BITS:0]   cos_addr;
    logic [SINE_TABLE_BITS:0]   mirror_addr;
    logic [sqt_pkg::SINE_W-1:0] sin_mag;
    logic [sqt_pkg::SINE_W-1:0] cos_mag;

    assign phase_idx   = i_angle[sqt_pkg::PHASE_W-1 -: SINE_TABLE_BITS];
    assign mirror_addr = QUARTER - {1'b0, phase_idx};
    assign sin_addr    = i_angle[sqt_pkg::PHASE_W] ? mirror_addr : {1'b0, phase_idx};
    assign cos_addr    = i_angle[sqt_pkg::PHASE_W] ? {1'b0, phase_idx} : mirror_addr;

    sqt_sine_rom #(
        .TABLE_BITS (SINE_TABLE_BITS)
    ) u_sine_rom (
        .i_clk    (i_clk),
        .i_en     (stage_en[STG_ROM]),
        .i_addr_a (sin_addr),
        .i_addr_b (cos_addr),
        .o_data_a (sin_mag),
        .o_data_b (cos_mag)
    );

    logic                                r_s0_sin_neg, r_s0_cos_neg;
    logic signed [LW-1:0]                r_s0_lx0, r_s0_lx1, r_s0_ly0, r_s0_ly1;
    logic signed [CW-1:0]                r_s0_dest_x, r_s0_dest_y;
    logic signed [sqt_pkg::SCALE_W-1:0]  r_s0_scale_x, r_s0_scale_y;

    always_ff @(posedge i_clk) begin
        if (stage_en[STG_ROM]) begin
            r_s0_sin_neg <= i_angle[sqt_pkg::ANGLE_W-1];
            r_s0_cos_neg <= i_angle[sqt_pkg::ANGLE_W-1] ^ i_angle[sqt_pkg::PHASE_W];
            // Local corners are -pivot and size - pivot
            r_s0_lx0     <= -LW'(i_pivot_x);
            r_s0_ly0     <= -LW'(i_pivot_y);
            r_s0_lx1     <= $signed({2'b00, i_size_w}) - LW'(i_pivot_x);
            r_s0_ly1     <= $signed({2'b00, i_size_h}) - LW'(i_pivot_y);
            r_s0_dest_x  <= i_dest_x;
            r_s0_dest_y  <= i_dest_y;
            r_s0_scale_x <= i_scale_x;
            r_s0_scale_y <= i_scale_y;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: matrix m11 = c*sx, m12 = -s*sy, m21 = s*sx, m22 = c*sy
    // Angle zero with unit scale gives the identity here, so the plain
    // offset case needs no path of its own.
    // ------------------------------------------------------------------
    logic signed [sqt_pkg::TRIG_W-1:0]  sin_val, cos_val, neg_sin_val;
    logic signed [sqt_pkg::COEF_W-1:0]  r_s1_m11, r_s1_m12, r_s1_m21, r_s1_m22;
    logic signed [LW-1:0]               r_s1_lx0, r_s1_lx1, r_s1_ly0, r_s1_ly1;
    logic signed [CW-1:0]               r_s1_dest_x, r_s1_dest_y;

    assign sin_val     = r_s0_sin_neg ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
    assign cos_val     = r_s0_cos_neg ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});
    assign neg_sin_val = -sin_val;

    always_ff @(posedge i_clk) begin
        if (stage_en[STG_COEF]) begin
            r_s1_m11    <= sqt_pkg::COEF_W'(cos_val * r_s0_scale_x);
            r_s1_m12    <= sqt_pkg::COEF_W'(neg_sin_val * r_s0_scale_y);
            r_s1_m21    <= sqt_pkg::COEF_W'(sin_val * r_s0_scale_x);
            r_s1_m22    <= sqt_pkg::COEF_W'(cos_val * r_s0_scale_y);
            r_s1_lx0    <= r_s0_lx0;
            r_s1_lx1    <= r_s0_lx1;
            r_s1_ly0    <= r_s0_ly0;
            r_s1_ly1    <= r_s0_ly1;
            r_s1_dest_x <= r_s0_dest_x;
            r_s1_dest_y <= r_s0_dest_y;
        end
    end

    // ------------------------------------------------------------------
    // Stages 2 to 4: one unit per axis
    // ------------------------------------------------------------------
    sqt_pkg::t_axis_en axis_en;

    assign axis_en.mul = stage_en[STG_MUL];
    assign axis_en.sum = stage_en[STG_SUM];
    assign axis_en.sat = stage_en[STG_SAT];

    logic signed [CW-1:0] cx [4];
    logic signed [CW-1:0] cy [4];

    sqt_axis u_axis_x (
        .i_clk  (i_clk),
        .i_en   (axis_en),
        .i_u0   (r_s1_lx0),
        .i_u1   (r_s1_lx1),
        .i_v0   (r_s1_ly0),
        .i_v1   (r_s1_ly1),
        .i_ma   (r_s1_m11),
        .i_mb   (r_s1_m12),
        .i_dest (r_s1_dest_x),
        .o_c0   (cx[0]),
        .o_c1   (cx[1]),
        .o_c2   (cx[2]),
        .o_c3   (cx[3])
    );

    sqt_axis u_axis_y (
        .i_clk  (i_clk),
        .i_en   (axis_en),
        .i_u0   (r_s1_lx0),
        .i_u1   (r_s1_lx1),
        .i_v0   (r_s1_ly0),
        .i_v1   (r_s1_ly1),
        .i_ma   (r_s1_m21),
        .i_mb   (r_s1_m22),
        .i_dest (r_s1_dest_y),
        .o_c0   (cy[0]),
        .o_c1   (cy[1]),
        .o_c2   (cy[2]),
        .o_c3   (cy[3])
    );

    // ------------------------------------------------------------------
    // Stage 5: bounding box of the saturated corners, output register
    // ------------------------------------------------------------------
    logic signed [CW-1:0] out_x [4];
    logic signed [CW-1:0] out_y [4];

    sqt_bbox u_bbox (
        .i_clk   (i_clk),
        .i_en    (stage_en[STG_OUT]),
        .i_x     (cx),
        .i_y     (cy),
        .o_x     (out_x),
        .o_y     (out_y),
        .o_min_x (o_box_min_x),
        .o_min_y (o_box_min_y),
        .o_max_x (o_box_max_x),
        .o_max_y (o_box_max_y)
    );

    // Corners clockwise from top left
    assign o_tl_x = out_x[0];
    assign o_tl_y = out_y[0];
    assign o_tr_x = out_x[1];
    assign o_tr_y = out_y[1];
    assign o_br_x = out_x[2];
    assign o_br_y = out_y[2];
    assign o_bl_x = out_x[3];
    assign o_bl_y = out_y[3];

endmodule
